/* src/arc_pkg.sv */
// ---------------------------------------------------------------------------
// arc_pkg: shared types and constants of the ARP cache resolver
// Field widths, stream packing widths, action codes and ARP header values.
// ---------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int ACT_W  = 3;

  // Input stream: op in tuser, the rest packed in tdata (200 bits, 25 bytes).
  localparam int IN_USER_W = 1;
  localparam int IN_DATA_W = 200;
  // Output stream: action in tuser, peer_ip and peer_mac in tdata (80 bits).
  localparam int OUT_USER_W = ACT_W;
  localparam int OUT_DATA_W = 80;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd3;

  localparam logic [IP_W-1:0] SUBNET_MASK_RST = 32'hFFFF_FF00;

  // Result actions
  localparam logic [ACT_W-1:0] ACT_IGNORED = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LEARNED = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REPLY   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SEND    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REQUEST = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MCAST   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_NOGW    = 3'd6;

  // Request kinds carried in in_tuser
  localparam logic OP_RX = 1'b0;
  localparam logic OP_TX = 1'b1;

  // ARP header values accepted on receive
  localparam logic [15:0] ARP_HW_ETHERNET = 16'h0001;
  localparam logic [15:0] ARP_PROTO_IPV4  = 16'h0800;
  localparam logic [7:0]  ARP_PLEN_IPV4   = 8'h04;
  localparam logic [15:0] ARP_OP_REQUEST  = 16'h0001;
  localparam logic [15:0] ARP_OP_REPLY    = 16'h0002;

  localparam logic [IP_W-1:0]  IP_BROADCAST  = 32'hFFFF_FFFF;
  localparam logic [3:0]       IP_MCAST_TOP  = 4'hE;
  localparam logic [MAC_W-1:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] stamp;
  } arc_entry_t;

endpackage

`default_nettype wire

/* src/arp_cache_resolver.sv */
// ---------------------------------------------------------------------------
// arp_cache_resolver: IPv4 ARP cache with next-hop resolution
// Learns senders of ARP requests and replies, answers requests, and resolves
// transmit destinations to MAC addresses through a table in one memory.
// ---------------------------------------------------------------------------
// One request is handled at a time. Requests that need no table access
// (rejected ARP packets, broadcast, multicast, no gateway) go straight from idle to done.
// A lookup or a learn scans the table memory one entry per cycle at
// one registered read port, and stops early when an entry matches. A new
// request is taken while the previous result still waits in the output
// register. Reset clears the per-entry valid bits; an entry that was never
// written reads as all zero (empty).
`default_nettype none

module arp_cache_resolver #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: hw_type[15:0], proto_type[31:16], proto_len[39:32],
  // arp_opcode[55:40], sender_ip[87:56], sender_mac[135:88],
  // target_ip[167:136], now[199:168]
  input  wire logic [arc_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: op[0]
  input  wire logic [arc_pkg::IN_USER_W-1:0]     in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: peer_ip[31:0], peer_mac[79:32]
  output logic [arc_pkg::OUT_DATA_W-1:0]         out_tdata,
  // out_tuser: action[2:0]
  output logic [arc_pkg::OUT_USER_W-1:0]         out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [arc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [arc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import arc_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Configuration registers
  logic [IP_W-1:0]  own_ip_r;
  logic [MAC_W-1:0] own_mac_r;
  logic [IP_W-1:0]  gateway_ip_r;
  logic [IP_W-1:0]  subnet_mask_r;

  // Control
  logic [1:0]       state_r, state_nxt;
  logic             learn_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic [IDX_W-1:0] victim_r;
  logic [TIME_W-1:0] held_r;
  logic [IDX_W-1:0] wr_idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  // Request and pending result
  logic [IP_W-1:0]   key_ip_r;
  logic [MAC_W-1:0]  key_mac_r;
  logic [TIME_W-1:0] now_r;
  logic [ACT_W-1:0]  res_act_r;
  logic [IP_W-1:0]   res_ip_r;
  logic [MAC_W-1:0]  res_mac_r;

  // Output register
  logic              out_valid_r;
  logic [ACT_W-1:0]  out_act_r;
  logic [IP_W-1:0]   out_ip_r;
  logic [MAC_W-1:0]  out_mac_r;

  // Table memory
  arc_entry_t mem [TABLE_ENTRIES];
  arc_entry_t rd_data_r;
  arc_entry_t ent;
  logic       rd_issue;
  logic       mem_we;

  // Input field unpacking
  logic             f_op;
  logic [15:0]      f_hw_type;
  logic [15:0]      f_proto_type;
  logic [7:0]       f_proto_len;
  logic [15:0]      f_opcode;
  logic [IP_W-1:0]  f_sender_ip;
  logic [MAC_W-1:0] f_sender_mac;
  logic [IP_W-1:0]  f_target_ip;
  logic [TIME_W-1:0] f_now;

  assign f_op         = in_tuser[0];
  assign f_hw_type    = in_tdata[15:0];
  assign f_proto_type = in_tdata[31:16];
  assign f_proto_len  = in_tdata[39:32];
  assign f_opcode     = in_tdata[55:40];
  assign f_sender_ip  = in_tdata[87:56];
  assign f_sender_mac = in_tdata[135:88];
  assign f_target_ip  = in_tdata[167:136];
  assign f_now        = in_tdata[199:168];

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r      <= '0;
      own_mac_r     <= '0;
      gateway_ip_r  <= '0;
      subnet_mask_r <= SUBNET_MASK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OWN_IP:      own_ip_r      <= cfg_data[IP_W-1:0];
        REG_OWN_MAC:     own_mac_r     <= cfg_data;
        REG_GATEWAY_IP:  gateway_ip_r  <= cfg_data[IP_W-1:0];
        REG_SUBNET_MASK: subnet_mask_r <= cfg_data[IP_W-1:0];
        default: ;
      endcase
    end
  end

  // Classification of an arriving request
  logic             arp_ok;
  logic             on_link;
  logic             cls_scan;
  logic             cls_learn;
  logic [ACT_W-1:0] cls_act;
  logic [IP_W-1:0]  cls_ip;
  logic [MAC_W-1:0] cls_mac;
  logic [IP_W-1:0]  cls_key;

  always_comb begin
    arp_ok = (f_hw_type == ARP_HW_ETHERNET) && (f_proto_type == ARP_PROTO_IPV4) &&
             (f_proto_len == ARP_PLEN_IPV4) && (f_target_ip == own_ip_r);
    on_link = ((f_target_ip ^ own_ip_r) & subnet_mask_r) == '0;
    cls_scan  = 1'b0;
    cls_learn = 1'b0;
    cls_act   = ACT_IGNORED;
    cls_ip    = '0;
    cls_mac   = '0;
    cls_key   = f_target_ip;
    if (f_op == OP_RX) begin
      cls_key = f_sender_ip;
      if (arp_ok && (f_opcode == ARP_OP_REQUEST || f_opcode == ARP_OP_REPLY)) begin
        cls_scan  = 1'b1;
        cls_learn = 1'b1;
        cls_act   = (f_opcode == ARP_OP_REQUEST) ? ACT_REPLY : ACT_LEARNED;
        cls_ip    = f_sender_ip;
        cls_mac   = f_sender_mac;
      end
    end else if (f_target_ip == IP_BROADCAST) begin
      cls_act = ACT_SEND;
      cls_ip  = f_target_ip;
      cls_mac = MAC_BROADCAST;
    end else if (f_target_ip[IP_W-1 -: 4] == IP_MCAST_TOP) begin
      cls_act = ACT_MCAST;
    end else if (on_link) begin
      cls_scan = 1'b1;
    end else if (gateway_ip_r == '0) begin
      cls_act = ACT_NOGW;
      cls_ip  = f_target_ip;
    end else begin
      cls_scan = 1'b1;
      cls_key  = gateway_ip_r;
    end
  end

  // Returned entry and scan decisions
  logic              ent_hit;
  logic              scan_last;
  logic              take_victim;
  logic [IDX_W-1:0]  victim_nxt;
  logic [TIME_W-1:0] held_nxt;

  always_comb begin
    ent = valid_r[chk_idx_r] ? rd_data_r : '0;
    ent_hit = (ent.ip == key_ip_r) || (learn_r && ent.ip == '0);
    scan_last = (chk_idx_r == IDX_LAST);
    // Running minimum over time stamps; a held time of zero is always replaced.
    take_victim = (held_r == '0) || (held_r > ent.stamp);
    victim_nxt  = take_victim ? chk_idx_r : victim_r;
    held_nxt    = take_victim ? ent.stamp : held_r;
  end

  assign rd_issue = (state_r == ST_SCAN) && (rd_cnt_r < CNT_END);
  assign mem_we   = (state_r == ST_WRITE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = cls_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (rd_vld_r) begin
          if (ent_hit) state_nxt = learn_r ? ST_WRITE : ST_DONE;
          else if (scan_last) state_nxt = learn_r ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_cnt_r <= '0;
      rd_vld_r <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_issue;
      if (in_acc) rd_cnt_r <= '0;
      else if (rd_issue) rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      if (mem_we) valid_r[wr_idx_r] <= 1'b1;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx_r] <= '{ip: key_ip_r, mac: key_mac_r, stamp: now_r};
    if (rd_issue) rd_data_r <= mem[rd_cnt_r[IDX_W-1:0]];
  end

  // Request payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rd_issue) chk_idx_r <= rd_cnt_r[IDX_W-1:0];
    if (in_acc) begin
      learn_r   <= cls_learn;
      key_ip_r  <= cls_key;
      key_mac_r <= f_sender_mac;
      now_r     <= f_now;
      res_act_r <= cls_act;
      res_ip_r  <= cls_ip;
      res_mac_r <= cls_mac;
      victim_r  <= '0;
      held_r    <= '0;
    end else if (state_r == ST_SCAN && rd_vld_r) begin
      if (ent_hit) begin
        wr_idx_r <= chk_idx_r;
        if (!learn_r) begin
          res_act_r <= ACT_SEND;
          res_ip_r  <= key_ip_r;
          res_mac_r <= ent.mac;
        end
      end else begin
        victim_r <= victim_nxt;
        held_r   <= held_nxt;
        if (scan_last) begin
          wr_idx_r <= victim_nxt;
          if (!learn_r) begin
            res_act_r <= ACT_REQUEST;
            res_ip_r  <= key_ip_r;
            res_mac_r <= '0;
          end
        end
      end
    end
  end

  // Output register
  logic out_load;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_act_r <= res_act_r;
      out_ip_r  <= res_ip_r;
      out_mac_r <= res_mac_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = {out_mac_r, out_ip_r};

`ifndef ASSERT_OFF
  // A written entry must be valid from the next cycle on.
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> valid_r[$past(wr_idx_r)])
    else $error("table write did not mark the entry valid");

  // No read data may still be in flight when a new request can be taken.
  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !rd_vld_r)
    else $error("stale table read in idle");

  // The read counter never runs past the table.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r <= CNT_END)
    else $error("table read counter overran");

  // A dropped multicast carries no peer addresses.
  a_mcast_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ACT_MCAST) |-> (out_tdata == '0))
    else $error("multicast drop with nonzero peer fields");
`endif

endmodule

`default_nettype wire

/* verif/arp_cache_resolver_tb.sv */
// ---------------------------------------------------------------------------
// arp_cache_resolver_tb: self-checking testbench of the ARP cache resolver
// A mirror of the cache table and registers predicts one result per request.
// Directed corner cases come first, then six register settings with random,
// mostly well-formed traffic, under random stalls on both streams.
// ---------------------------------------------------------------------------

module arp_cache_resolver_tb;
  import arc_pkg::*;

  typedef struct packed {
    logic              op;
    logic [15:0]       hw_type;
    logic [15:0]       proto_type;
    logic [7:0]        proto_len;
    logic [15:0]       arp_opcode;
    logic [IP_W-1:0]   sender_ip;
    logic [MAC_W-1:0]  sender_mac;
    logic [IP_W-1:0]   target_ip;
    logic [TIME_W-1:0] now;
  } arc_req_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IP_W-1:0]  peer_ip;
    logic [MAC_W-1:0] peer_mac;
  } arc_result_t;

  // Keeps its own copy of the registers and the table, and the queue of
  // results the block still owes.
  class arc_cache_mirror #(int DEPTH = 16);
    logic [IP_W-1:0]   own_ip;
    logic [MAC_W-1:0]  own_mac;
    logic [IP_W-1:0]   gateway_ip;
    logic [IP_W-1:0]   subnet_mask;
    logic [IP_W-1:0]   tab_ip[DEPTH];
    logic [MAC_W-1:0]  tab_mac[DEPTH];
    logic [TIME_W-1:0] tab_time[DEPTH];
    arc_result_t       awaited_results[$];
    int                errors;

    function new();
      own_ip      = '0;
      own_mac     = '0;
      gateway_ip  = '0;
      subnet_mask = SUBNET_MASK_RST;
      foreach (tab_ip[i]) begin
        tab_ip[i]   = '0;
        tab_mac[i]  = '0;
        tab_time[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_OWN_IP:      own_ip = data[IP_W-1:0];
        REG_OWN_MAC:     own_mac = data[MAC_W-1:0];
        REG_GATEWAY_IP:  gateway_ip = data[IP_W-1:0];
        REG_SUBNET_MASK: subnet_mask = data[IP_W-1:0];
        default: ;
      endcase
    endfunction

    // Overwrite the first matching or empty entry; otherwise evict the entry
    // picked by the running oldest-stamp scan, where a held stamp of zero
    // always gives way.
    function void learn_entry(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                              logic [TIME_W-1:0] stamp);
      int slot;
      int victim;
      logic [TIME_W-1:0] held;
      slot   = -1;
      victim = 0;
      held   = '0;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot < 0) begin
          if (tab_ip[i] == ip || tab_ip[i] == '0) begin
            slot = i;
          end else if (held == '0 || held > tab_time[i]) begin
            victim = i;
            held   = tab_time[i];
          end
        end
      end
      if (slot < 0) slot = victim;
      tab_ip[slot]   = ip;
      tab_mac[slot]  = mac;
      tab_time[slot] = stamp;
    endfunction

    function arc_result_t resolve_request(arc_req_t r);
      arc_result_t res;
      logic [IP_W-1:0] hop;
      res = '0;
      if (r.op == OP_RX) begin
        if (r.hw_type == ARP_HW_ETHERNET && r.proto_type == ARP_PROTO_IPV4 &&
            r.proto_len == ARP_PLEN_IPV4 && r.target_ip == own_ip &&
            (r.arp_opcode == ARP_OP_REQUEST || r.arp_opcode == ARP_OP_REPLY)) begin
          learn_entry(r.sender_ip, r.sender_mac, r.now);
          res.action   = (r.arp_opcode == ARP_OP_REQUEST) ? ACT_REPLY : ACT_LEARNED;
          res.peer_ip  = r.sender_ip;
          res.peer_mac = r.sender_mac;
        end else begin
          res.action = ACT_IGNORED;
        end
      end else if (r.target_ip == IP_BROADCAST) begin
        res.action   = ACT_SEND;
        res.peer_ip  = r.target_ip;
        res.peer_mac = MAC_BROADCAST;
      end else if (r.target_ip[IP_W-1 -: 4] == IP_MCAST_TOP) begin
        res.action = ACT_MCAST;
      end else if ((r.target_ip & subnet_mask) != (own_ip & subnet_mask) &&
                   gateway_ip == '0) begin
        res.action  = ACT_NOGW;
        res.peer_ip = r.target_ip;
      end else begin
        hop = ((r.target_ip & subnet_mask) == (own_ip & subnet_mask)) ?
              r.target_ip : gateway_ip;
        res.action  = ACT_REQUEST;
        res.peer_ip = hop;
        // Scan downward so that the first matching entry wins; a next hop of
        // zero matches an empty entry.
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (tab_ip[i] == hop) begin
            res.action   = ACT_SEND;
            res.peer_mac = tab_mac[i];
          end
        end
      end
      return res;
    endfunction

    function void note_request(arc_req_t r);
      arc_result_t res;
      res = resolve_request(r);
      awaited_results.push_back(res);
    endfunction

    function void check_result(logic [ACT_W-1:0] action, logic [OUT_DATA_W-1:0] data);
      arc_result_t want;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
      ip  = data[IP_W-1:0];
      mac = data[IP_W +: MAC_W];
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with none pending: action %0d peer_ip %h peer_mac %h",
                   $time, action, ip, mac);
        return;
      end
      want = awaited_results.pop_front();
      if (action !== want.action || ip !== want.peer_ip || mac !== want.peer_mac) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch action %0d/%0d peer_ip %h/%h peer_mac %h/%h (exp/act)",
                   $time, want.action, action, want.peer_ip, ip, want.peer_mac, mac);
      end
    endfunction
  endclass

  localparam int TABLE_DEPTH      = 16;
  localparam int CLK_PERIOD       = 12;
  localparam int POOL_SIZE        = 24;
  localparam int ITEMS_PER_PHASE  = 250;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = TABLE_DEPTH + 8;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  arp_cache_resolver #(
    .TABLE_ENTRIES(TABLE_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  arc_cache_mirror #(TABLE_DEPTH) mirror;

  logic [IP_W-1:0]   cur_own_ip = '0;
  logic [IP_W-1:0]   ip_pool[POOL_SIZE];
  logic [TIME_W-1:0] stamp_clock = '0;
  bit                send_calm = 1'b0;
  bit                recv_calm = 1'b0;
  bit                long_hold = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic arc_req_t arp_packet(logic [15:0] opcode, logic [IP_W-1:0] sip,
                                          logic [MAC_W-1:0] smac, logic [IP_W-1:0] tip,
                                          logic [TIME_W-1:0] stamp);
    arc_req_t r;
    r.op         = OP_RX;
    r.hw_type    = ARP_HW_ETHERNET;
    r.proto_type = ARP_PROTO_IPV4;
    r.proto_len  = ARP_PLEN_IPV4;
    r.arp_opcode = opcode;
    r.sender_ip  = sip;
    r.sender_mac = smac;
    r.target_ip  = tip;
    r.now        = stamp;
    return r;
  endfunction

  // The ARP header fields carry noise on a transmit request.
  function automatic arc_req_t tx_request(logic [IP_W-1:0] dest);
    arc_req_t r;
    r.op         = OP_TX;
    r.hw_type    = 16'($urandom);
    r.proto_type = 16'($urandom);
    r.proto_len  = 8'($urandom);
    r.arp_opcode = 16'($urandom);
    r.sender_ip  = $urandom;
    r.sender_mac = rand_mac();
    r.target_ip  = dest;
    r.now        = $urandom;
    return r;
  endfunction

  function automatic arc_req_t random_request();
    arc_req_t r;
    int kind;
    int sel;
    logic [TIME_W-1:0] stamp;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      stamp = '0;
    end else if (sel == 1) begin
      stamp = '1;
    end else if (sel == 2) begin
      stamp = $urandom;
    end else begin
      stamp_clock += $urandom_range(1, 50);
      stamp = stamp_clock;
    end
    r = arp_packet($urandom_range(0, 1) ? ARP_OP_REQUEST : ARP_OP_REPLY,
                   ip_pool[$urandom_range(0, POOL_SIZE - 1)], rand_mac(), cur_own_ip, stamp);
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      if ($urandom_range(0, 19) == 0) r.arp_opcode = 16'($urandom);
    end else if (kind < 75) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) r = tx_request(IP_BROADCAST);
      else if (sel == 1) r = tx_request({IP_MCAST_TOP, 28'($urandom)});
      else if (sel == 2) r = tx_request($urandom);
      else r = tx_request(ip_pool[$urandom_range(0, POOL_SIZE - 1)]);
    end else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0: r.hw_type = 16'($urandom);
        1: r.proto_type = 16'($urandom);
        2: r.proto_len = 8'($urandom);
        default: r.target_ip = $urandom;
      endcase
    end else begin
      r.op         = 1'($urandom);
      r.hw_type    = 16'($urandom);
      r.proto_type = 16'($urandom);
      r.proto_len  = 8'($urandom);
      r.arp_opcode = 16'($urandom);
      r.sender_ip  = $urandom;
      r.sender_mac = rand_mac();
      r.target_ip  = $urandom;
      r.now        = $urandom;
    end
    return r;
  endfunction

  // Leaves in_tvalid high after the handshake; the caller lowers it before
  // it stops offering requests.
  task automatic send_request(input arc_req_t r);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {r.now, r.target_ip, r.sender_mac, r.sender_ip,
                  r.arp_opcode, r.proto_len, r.proto_type, r.hw_type};
    in_tuser  <= r.op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    mirror.note_request(r);
  endtask

  task automatic wait_drained();
    while (mirror.awaited_results.size() != 0) @(posedge clk);
  endtask

  // Writes all four registers and rebuilds the address pool around the new
  // subnet, with the gateway in it so that it gets learned too.
  task automatic set_config(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                            input logic [IP_W-1:0] gw, input logic [IP_W-1:0] mask);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx = '{REG_OWN_IP, REG_OWN_MAC, REG_GATEWAY_IP, REG_SUBNET_MASK};
    val = '{CFG_DATA_W'(ip), mac, CFG_DATA_W'(gw), CFG_DATA_W'(mask)};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      mirror.set_reg(idx[k], val[k]);
    end
    cfg_valid  <= 1'b0;
    cur_own_ip = ip;
    for (int k = 0; k < POOL_SIZE; k++) begin
      if (k == 0) ip_pool[k] = gw;
      else if (k < 20) ip_pool[k] = (ip & mask) | (IP_W'($urandom) & ~mask);
      else ip_pool[k] = $urandom;
    end
  endtask

  initial begin
    arc_req_t r;
    int sent;
    mirror = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a next hop of zero matches an empty entry, and learning
    // address zero fills the first slot and marks it valid.
    send_request(tx_request(32'h0000_0000));
    send_request(tx_request(32'h0808_0808));
    send_request(arp_packet(ARP_OP_REPLY, 32'h0, 48'h0A0B_0C0D_0E0F, 32'h0, 32'h10));
    send_request(tx_request(32'h0000_0000));
    in_tvalid <= 1'b0;
    wait_drained();

    set_config(32'hC0A8_010A, rand_mac(), 32'hC0A8_0101, 32'hFFFF_FF00);
    send_request(arp_packet(ARP_OP_REQUEST, 32'hC0A8_0101, '1, 32'hC0A8_010A, '1));
    send_request(arp_packet(ARP_OP_REPLY, 32'hC0A8_0114, 48'h1, 32'hC0A8_010A, '0));
    send_request(arp_packet(16'h0003, 32'hC0A8_0115, rand_mac(), 32'hC0A8_010A, 32'h5));
    send_request(arp_packet(16'h0000, 32'hC0A8_0116, rand_mac(), 32'hC0A8_010A, 32'h6));
    send_request(arp_packet(16'hFFFF, 32'hC0A8_0117, rand_mac(), 32'hC0A8_010A, 32'h7));
    r = arp_packet(ARP_OP_REPLY, 32'hC0A8_0118, rand_mac(), 32'hC0A8_010A, 32'h8);
    r.hw_type = 16'h0000;
    send_request(r);
    r.hw_type    = ARP_HW_ETHERNET;
    r.proto_type = 16'h86DD;
    send_request(r);
    r.proto_type = ARP_PROTO_IPV4;
    r.proto_len  = 8'hFF;
    send_request(r);
    r.proto_len = ARP_PLEN_IPV4;
    r.target_ip = 32'hC0A8_010B;
    send_request(r);
    send_request(tx_request(IP_BROADCAST));
    send_request(tx_request(32'hE000_0000));
    send_request(tx_request(32'hEFFF_FFFF));
    send_request(tx_request(32'hF000_0000));
    send_request(tx_request(32'hDFFF_FFFF));
    send_request(tx_request(32'hC0A8_0114));
    send_request(tx_request(32'hC0A8_0163));
    send_request(arp_packet(ARP_OP_REQUEST, 32'hC0A8_0114, 48'hFFFF_0000_FFFF,
                            32'hC0A8_010A, 32'h20));
    send_request(tx_request(32'hC0A8_0114));

    for (int p = 1; p <= 6; p++) begin
      in_tvalid <= 1'b0;
      wait_drained();
      case (p)
        1: set_config(32'hC0A8_010A, rand_mac(), 32'hC0A8_0101, 32'hFFFF_FF00);
        2: set_config($urandom, '0, $urandom, 32'h0000_0000);
        3: set_config($urandom, '1, 32'h0000_0000, 32'hFFFF_FFFF);
        4: set_config(32'h0000_0000, rand_mac(), 32'h0A00_0001, 32'hFFFF_0000);
        5: set_config(32'hFFFF_FFFF, rand_mac(), 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        default: set_config($urandom, rand_mac(), $urandom,
                            32'hFFFF_FFFF << $urandom_range(0, 31));
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // In the first phase the receiver stalls for long while requests keep
        // coming, and later the sender stops until the block has drained.
        if (p == 1 && sent == 40) long_hold = 1'b1;
        if (p == 1 && sent == 150) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
        send_request(random_request());
        sent++;
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mirror.errors += mirror.awaited_results.size();
    if (mirror.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        gap = recv_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      mirror.check_result(out_tuser, out_tdata);
    end
  end

  initial begin
    #(CLK_PERIOD * 600000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
